FILE: hw/rtl/spsc_pkg.sv
// Shared widths and defaults for the stack pop sequence checker.
package spsc_pkg;
	localparam int VAL_W         = 10;
	localparam int NEXT_W        = 11;
	localparam int CFG_W         = 11;
	localparam int MAX_DEPTH_DEF = 1024;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);
endpackage

FILE: hw/rtl/spsc_if.sv
// Valid/ready channel interfaces for popped values and verdicts.
interface spsc_pop_if;
	logic                      valid;
	logic                      ready;
	logic [spsc_pkg::VAL_W-1:0] pop_value;
	logic                      last_of_sequence;

	modport source (output valid, output pop_value, output last_of_sequence, input ready);
	modport sink   (input valid, input pop_value, input last_of_sequence, output ready);
endinterface

interface spsc_verdict_if;
	logic valid;
	logic ready;
	logic sequence_possible;

	modport source (output valid, output sequence_possible, input ready);
	modport sink   (input valid, input sequence_possible, output ready);
endinterface

FILE: hw/rtl/stack_pop_sequence_checker.sv
// Top level of the stack pop sequence checker with its push sequencer.
// An item whose value is on top goes from acceptance through S_CMP and S_DONE to idle;
// an item that needs pushes also passes through S_PUSH, one stack RAM write per push.
// The verdict of a final item is registered as S_DONE ends, once the output register is free.
// Throughput: one item at a time; the input is ready only while the sequencer idles.
// Reset clears the stack depth, failure flag and output valid, sets the push counter to one
// and sets the capacity to 1024; the stack RAM needs no clearing.
module stack_pop_sequence_checker #(
	parameter int MAX_DEPTH = spsc_pkg::MAX_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       stack_capacity_we,
	input  logic [spsc_pkg::CFG_W-1:0] stack_capacity_wdata,
	spsc_pop_if.sink                   pop,
	spsc_verdict_if.source             verdict
);
	import spsc_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = (DW > CFG_W) ? DW : CFG_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] cap_cfg_q;
	logic [DW-1:0]    depth_q;
	logic [NEXT_W-1:0] next_q;
	logic             failed_q;
	logic             pushed_q;
	logic [VAL_W-1:0] value_q;
	logic             last_q;
	logic             out_valid_q;
	logic             out_bit_q;

	logic [CW-1:0]     cfg_wide;
	logic [DW-1:0]     cap_eff;
	logic [NEXT_W-1:0] value_ext;
	logic [VAL_W-1:0]  top_data;
	logic              can_push;
	logic              wr_en;
	logic              accept;
	logic              out_free;
	logic              out_load;

	assign cfg_wide  = CW'(cap_cfg_q);
	assign cap_eff   = (cfg_wide > CW'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(cfg_wide);
	assign value_ext = {1'b0, value_q};
	assign can_push  = (next_q <= value_ext) && (depth_q < cap_eff);
	assign wr_en     = (state_q == S_PUSH) && can_push;
	assign accept    = pop.valid && pop.ready;
	assign out_free  = !out_valid_q || verdict.ready;
	assign out_load  = (state_q == S_DONE) && last_q && out_free;

	assign pop.ready                 = (state_q == S_IDLE);
	assign verdict.valid             = out_valid_q;
	assign verdict.sequence_possible = out_bit_q;

	spsc_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (wr_en),
		.waddr(depth_q[AW-1:0]),
		.wdata(next_q[VAL_W-1:0]),
		.raddr(AW'(depth_q - DW'(1))),
		.rdata(top_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= CAP_RESET;
		end else if (stack_capacity_we) begin
			cap_cfg_q <= stack_capacity_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= pop.pop_value;
			last_q  <= pop.last_of_sequence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			next_q      <= NEXT_W'(1);
			failed_q    <= 1'b0;
			pushed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			if (verdict.valid && verdict.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pushed_q <= 1'b0;
						state_q  <= failed_q ? S_DONE : S_CMP;
					end
				end
				S_CMP: begin
					if ((depth_q != '0) && (top_data == value_q)) begin
						depth_q <= depth_q - DW'(1);
						state_q <= S_DONE;
					end else if (value_ext < next_q) begin
						failed_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (can_push) begin
						depth_q  <= depth_q + DW'(1);
						next_q   <= next_q + NEXT_W'(1);
						pushed_q <= 1'b1;
					end else begin
						if (pushed_q && (next_q == value_ext + NEXT_W'(1))) begin
							depth_q <= depth_q - DW'(1);
						end else begin
							failed_q <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_bit_q   <= !failed_q;
						depth_q     <= '0;
						next_q      <= NEXT_W'(1);
						failed_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("stack depth exceeds the RAM depth");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (depth_q < cap_eff) && (next_q <= value_ext))
		else $error("push beyond capacity or past the value");

	a_failed_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && failed_q) |=> (state_q == S_DONE))
		else $error("item after a failure was not skipped");

	a_next_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q != $past(next_q)) |->
			((next_q == $past(next_q) + NEXT_W'(1)) || (next_q == NEXT_W'(1))))
		else $error("push counter moved other than by one or a clear");
endmodule

FILE: hw/rtl/spsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spsc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: tb/tb_stack_pop_sequence_checker.sv
// Self-checking testbench for the stack pop sequence checker, with a verdict predictor.
`timescale 1ns / 100ps

module tb_stack_pop_sequence_checker;
	import spsc_pkg::*;

	localparam int          DEPTH      = MAX_DEPTH_DEF;
	localparam int          IDLE_PAUSE = 1100;
	localparam int unsigned LIMIT      = 2000000;

	logic             clk;
	logic             arst_n;
	logic             stack_capacity_we;
	logic [CFG_W-1:0] stack_capacity_wdata;

	spsc_pop_if     pop_ch();
	spsc_verdict_if verdict_ch();

	stack_pop_sequence_checker i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.stack_capacity_we    (stack_capacity_we),
		.stack_capacity_wdata (stack_capacity_wdata),
		.pop                  (pop_ch),
		.verdict              (verdict_ch)
	);

	logic [VAL_W-1:0] shadow_stack [DEPTH];
	int unsigned      stack_level = 0;
	int unsigned      next_push = 1;
	bit               seq_failed = 1'b0;
	logic [CFG_W-1:0] capacity = CAP_RESET;
	bit               expected_verdicts [$];
	int unsigned      sent_items = 0;
	int unsigned      mismatches = 0;
	int unsigned      cycle_count = 0;
	bit               no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned usable_capacity();
		return (capacity > DEPTH) ? DEPTH : capacity;
	endfunction

	function automatic bit top_holds(int unsigned v);
		if (stack_level == 0) begin
			return 1'b0;
		end
		return shadow_stack[stack_level - 1] == v;
	endfunction

	function automatic void apply_pop(int unsigned v);
		int unsigned room;
		room = usable_capacity();
		if (top_holds(v)) begin
			stack_level--;
			return;
		end
		if (v < next_push) begin
			seq_failed = 1'b1;
			return;
		end
		while (next_push <= v && stack_level < room) begin
			shadow_stack[stack_level] = VAL_W'(next_push);
			stack_level++;
			next_push++;
		end
		if (top_holds(v)) begin
			stack_level--;
		end else begin
			seq_failed = 1'b1;
		end
	endfunction

	function automatic void track_pop(int unsigned v, bit last);
		if (!seq_failed) begin
			apply_pop(v);
		end
		if (last) begin
			expected_verdicts.push_back(!seq_failed);
			stack_level = 0;
			next_push   = 1;
			seq_failed  = 1'b0;
		end
	endfunction

	// Valid is left high after an item is taken, so a back-to-back item never toggles it.
	task automatic send_pop(input int unsigned v, input bit last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pop_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pop_ch.valid            <= 1'b1;
		pop_ch.pop_value        <= VAL_W'(v);
		pop_ch.last_of_sequence <= last;
		do @(posedge clk); while (!pop_ch.ready);
		sent_items++;
		track_pop(v, last);
	endtask

	task automatic send_list(input int unsigned vals []);
		foreach (vals[i]) begin
			send_pop(vals[i], i == vals.size() - 1);
		end
	endtask

	task automatic drain();
		pop_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] cap);
		drain();
		repeat (IDLE_PAUSE) @(posedge clk);
		stack_capacity_we    <= 1'b1;
		stack_capacity_wdata <= cap;
		@(posedge clk);
		capacity = cap;
		stack_capacity_we <= 1'b0;
	endtask

	// Builds a pop order by running a real stack, then optionally damages it.
	task automatic send_sequence(input int len, input int unsigned bound, input bit corrupt);
		int unsigned vals [$];
		int unsigned held [$];
		int unsigned nxt;
		int unsigned space;
		int unsigned k;
		int unsigned tmp;
		int          pos;
		int          other;
		bit          do_pop;
		nxt = 1;
		while (vals.size() < len) begin
			space = (usable_capacity() > held.size()) ? usable_capacity() - held.size() : 0;
			do_pop = held.size() > 0 && (nxt > bound || (space == 0 &&
				$urandom_range(0, 9) != 0) || $urandom_range(0, 2) == 0);
			if (do_pop) begin
				vals.push_back(held.pop_back());
			end else if (nxt <= bound) begin
				k = $urandom_range(1, bound - nxt + 1);
				if (space > 0 && k > space && $urandom_range(0, 9) != 0) begin
					k = space;
				end
				repeat (k) begin
					held.push_back(nxt);
					nxt++;
				end
				vals.push_back(held.pop_back());
			end else begin
				break;
			end
		end
		if (corrupt) begin
			pos = $urandom_range(0, vals.size() - 1);
			if ($urandom_range(0, 1) == 0) begin
				vals[pos] = $urandom_range(0, bound);
			end else begin
				other       = $urandom_range(0, vals.size() - 1);
				tmp         = vals[pos];
				vals[pos]   = vals[other];
				vals[other] = tmp;
			end
		end
		foreach (vals[i]) begin
			send_pop(vals[i], i == vals.size() - 1);
		end
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			send_pop($urandom_range(0, 1023), i == len - 1 || $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic run_random_sequence();
		int          kind;
		int          pick;
		int          len;
		int unsigned bound;
		kind = $urandom_range(0, 9);
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			bound = $urandom_range(1, 20);
		end else if (pick < 95) begin
			bound = $urandom_range(21, 120);
		end else begin
			bound = $urandom_range(121, 1023);
		end
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		if (kind < 7) begin
			send_sequence(len, bound, 1'b0);
		end else if (kind < 9) begin
			send_sequence(len, bound, 1'b1);
		end else begin
			send_noise();
		end
	endtask

	task automatic test_known_sequences();
		send_list('{1});
		send_list('{1023, 1022});
		send_list('{0});
		send_list('{3, 1, 2});
		send_list('{2, 1, 3});
		send_list('{1, 1});
		send_list('{3, 1, 5, 4});
		send_list('{512, 511, 513});
	endtask

	task automatic test_capacity_limits();
		set_capacity(CFG_W'(0));
		send_list('{1});
		set_capacity(CFG_W'(1));
		send_list('{1, 2});
		send_list('{2, 1});
		set_capacity(CFG_W'(2047));
		send_list('{1023});
		set_capacity(CFG_W'(1025));
		send_list('{5, 4});
		set_capacity(CFG_W'(1023));
		send_list('{1023});
	endtask

	task automatic test_random_traffic();
		int unsigned      target;
		logic [CFG_W-1:0] cap;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 5))
				0: cap = CFG_W'(1024);
				1: cap = CFG_W'($urandom_range(1, 4));
				2: cap = CFG_W'($urandom_range(5, 32));
				3: cap = CFG_W'($urandom_range(1025, 2047));
				default: cap = CFG_W'($urandom_range(1, 1024));
			endcase
			set_capacity(cap);
			no_idle = ($urandom_range(0, 3) == 0);
			target  = sent_items + 240;
			while (sent_items < target) begin
				run_random_sequence();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int stall;
		bit want;
		verdict_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual %0b",
					$time, verdict_ch.sequence_possible);
				mismatches++;
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict_ch.sequence_possible !== want) begin
					$display("%0t: sequence_possible mismatch, expected %0b, actual %0b",
						$time, want, verdict_ch.sequence_possible);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n                  <= 1'b0;
		stack_capacity_we       <= 1'b0;
		stack_capacity_wdata    <= '0;
		pop_ch.valid            <= 1'b0;
		pop_ch.pop_value        <= '0;
		pop_ch.last_of_sequence <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_sequences();
		test_capacity_limits();
		test_random_traffic();
		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
